/* hw/rtl/hbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants for the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // Input command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_PPU_X    = 3'd3;
  localparam logic [2:0] REG_PPU_Z    = 3'd4;
  localparam logic [2:0] REG_MAP_W    = 3'd5;
  localparam logic [2:0] REG_MAP_H    = 3'd6;
  localparam logic [2:0] REG_SCALE    = 3'd7;

  // Classified work item passed from the front to the back.
  typedef struct packed {
    logic        is_query;
    logic        in_map;
    logic [15:0] addr;     // load address, or base address of the cell
    logic [31:0] value;    // stored height for loads
    logic [15:0] frac_x;
    logic [15:0] frac_z;
  } work_t;

endpackage
`default_nettype wire

/* hw/rtl/heightmap_bilinear_sampler_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_core
// Heightmap store with bilinear ground-height queries.
// ----------------------------------------------------------------------------
// Usage: items arrive as beats on the in channel (in_valid, in_stall). A
// load beat writes one Q16.16 height into the store and yields no result. A
// query beat yields one result beat on the out channel (out_valid,
// out_stall) carrying ground_height and inside_map.
// The front takes one item at a time: in_stall is high after each accepted
// beat while it classifies the item and hands it to a two-entry queue. The
// back writes a load into its store. For a query inside the map it reads
// four neighbors from its single-port store and blends them; a query
// outside the map goes straight to its result beat.
// Reset clears all control state and restores the register defaults; the
// store holds no defined data until written. When the receiver stalls, the
// result beat holds, the back stops taking work, the queue fills and the
// front then holds its finished item, so no further beat is accepted.
// Registers are written over the APB port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command,
  input  wire logic [15:0]        pixel_index,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  input  wire logic signed [31:0] world_x,
  input  wire logic signed [31:0] world_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      ground_height,
  output logic                    inside_map
);
  import hbs_pkg::*;

  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [31:0] ppu_x;
  logic [31:0] ppu_z;
  logic [8:0]  map_w;
  logic [8:0]  map_h;
  logic [31:0] scale;
  logic [2:0]  ridx;
  logic [8:0]  w_c;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= 32'd0;
      origin_y <= 32'd0;
      origin_z <= 32'd0;
      ppu_x    <= 32'd65536;
      ppu_z    <= 32'd65536;
      map_w    <= 9'd256;
      map_h    <= 9'd256;
      scale    <= 32'd65536;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ORIGIN_X: origin_x <= pwdata;
        REG_ORIGIN_Y: origin_y <= pwdata;
        REG_ORIGIN_Z: origin_z <= pwdata;
        REG_PPU_X:    ppu_x    <= pwdata;
        REG_PPU_Z:    ppu_z    <= pwdata;
        REG_MAP_W:    map_w    <= pwdata[8:0];
        REG_MAP_H:    map_h    <= pwdata[8:0];
        REG_SCALE:    scale    <= pwdata;
        default:      ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (ridx)
      REG_ORIGIN_X: prdata = origin_x;
      REG_ORIGIN_Y: prdata = origin_y;
      REG_ORIGIN_Z: prdata = origin_z;
      REG_PPU_X:    prdata = ppu_x;
      REG_PPU_Z:    prdata = ppu_z;
      REG_MAP_W:    prdata = {23'd0, map_w};
      REG_MAP_H:    prdata = {23'd0, map_h};
      default:      prdata = scale;
    endcase
  end

  // Clamped row width for neighbor addressing.
  always_comb begin
    if (map_w < 9'd2) w_c = 9'd2;
    else if (32'(map_w) > 32'(MAX_WIDTH)) w_c = 9'(MAX_WIDTH);
    else w_c = map_w;
  end

  logic  f_valid;
  logic  f_stall;
  work_t f_data;
  logic  b_valid;
  logic  b_stall;
  work_t b_data;

  hbs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .pixel_index, .red, .green,
    .blue, .world_x, .world_z, .origin_x, .origin_y, .origin_z,
    .ppu_x, .ppu_z, .map_w, .map_h, .scale,
    .wk_valid(f_valid), .wk_stall(f_stall), .wk(f_data)
  );

  hbs_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
  );

  hbs_back u_back (
    .clk, .rst, .wk_valid(b_valid), .wk_stall(b_stall), .wk(b_data),
    .map_w_c(w_c), .out_valid, .out_stall,
    .ground_height, .inside_map
  );
endmodule
`default_nettype wire

/* hw/rtl/hbs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_front
// Accepts items and classifies them: computes the stored height of a load,
// and the cell, weights and inside flag of a query, over states S1 to S4.
// ----------------------------------------------------------------------------
module hbs_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command,
  input  wire logic [15:0]        pixel_index,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  input  wire logic signed [31:0] world_x,
  input  wire logic signed [31:0] world_z,
  input  wire logic [31:0]        origin_x,
  input  wire logic [31:0]        origin_y,
  input  wire logic [31:0]        origin_z,
  input  wire logic [31:0]        ppu_x,
  input  wire logic [31:0]        ppu_z,
  input  wire logic [8:0]         map_w,
  input  wire logic [8:0]         map_h,
  input  wire logic [31:0]        scale,
  output logic                    wk_valid,
  input  wire logic               wk_stall,
  output hbs_pkg::work_t          wk
);
  import hbs_pkg::*;

  localparam int SZW = $clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1) ?
                       $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);

  // Sequencer over one item.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1   = 3'd1;
  localparam logic [2:0] ST_S2   = 3'd2;
  localparam logic [2:0] ST_S3   = 3'd3;
  localparam logic [2:0] ST_S4   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state;
  logic               cmd;
  logic [15:0]        pidx;
  logic [9:0]         csum;
  logic signed [32:0] dx_d;
  logic signed [32:0] dz_d;
  logic [63:0]        mag_x;
  logic [63:0]        mag_z;
  logic               neg_x;
  logic               neg_z;
  logic signed [33:0] ysum;
  logic signed [65:0] prod;
  logic [SZW-1:0]     w_c;
  logic [SZW-1:0]     h_c;
  logic               ok_x;
  logic               ok_z;
  logic [31:0]        cell_x;
  logic [31:0]        cell_z;
  logic [15:0]        fx;
  logic [15:0]        fz;
  work_t              res;

  // Clamp the map sizes to the supported range.
  always_comb begin
    if (map_w < 9'd2) w_c = SZW'(2);
    else if (32'(map_w) > 32'(MAX_WIDTH)) w_c = SZW'(MAX_WIDTH);
    else w_c = SZW'(map_w);
    if (map_h < 9'd2) h_c = SZW'(2);
    else if (32'(map_h) > 32'(MAX_HEIGHT)) h_c = SZW'(MAX_HEIGHT);
    else h_c = SZW'(map_h);
  end

  // Normalized height of a load: round((sum-384)*512/3) in Q16.16.
  // The divide by three is a reciprocal multiply, exact below 2^21.
  logic [19:0] nh_num;
  logic [39:0] nh_prod;
  logic signed [31:0] nh;
  always_comb begin
    nh_num  = 20'({csum, 9'd0}) + 20'd1;
    nh_prod = 40'(nh_num) * 40'd699051;
    nh = 32'(signed'({1'b0, nh_prod[39:21]})) - 32'sd65536;
  end

  // Image mapping check, one axis.
  function automatic logic map_axis(input logic neg, input logic [63:0] mag,
                                    input logic [SZW-1:0] size, output logic [31:0] cidx,
                                    output logic [15:0] frac);
    logic [63:0] half;
    logic [63:0] limit;
    logic [63:0] pos;
    logic        ok;
    half  = 64'(size) << 31;
    limit = 64'(size - SZW'(1)) << 32;
    ok    = 1'b1;
    pos   = 64'd0;
    if (neg) begin
      if (mag > half) ok = 1'b0;
      pos = half - mag;
    end else begin
      if (mag >= limit - half) ok = 1'b0;
      pos = mag + half;
    end
    if (pos >= limit) ok = 1'b0;
    cidx = pos[63:32];
    frac = pos[31:16];
    return ok;
  endfunction

  logic [31:0] cx_n;
  logic [31:0] cz_n;
  logic [15:0] fx_n;
  logic [15:0] fz_n;
  logic        okx_n;
  logic        okz_n;
  always_comb begin
    okx_n = map_axis(neg_x, mag_x, w_c, cx_n, fx_n);
    okz_n = map_axis(neg_z, mag_z, h_c, cz_n, fz_n);
  end

  // Rounded, saturated stored height.
  logic signed [65:0] rnd;
  logic signed [49:0] shr;
  logic [31:0]        sat;
  always_comb begin
    rnd = prod + 66'sd32768;
    shr = 50'(rnd >>> 16);
    if (shr > 50'sd2147483647) sat = 32'h7FFF_FFFF;
    else if (shr < -50'sd2147483648) sat = 32'h8000_0000;
    else sat = shr[31:0];
  end

  assign in_stall = (state != ST_IDLE);
  assign wk_valid = (state == ST_OUT);
  assign wk       = res;

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd   <= command;
            pidx  <= pixel_index;
            csum  <= 10'(red) + 10'(green) + 10'(blue);
            dx_d  <= 33'(world_x) - 33'(signed'(origin_x));
            dz_d  <= 33'(world_z) - 33'(signed'(origin_z));
            state <= ST_S1;
          end
        end
        ST_S1: begin
          // Magnitudes of the offsets times pixels per unit; load sum.
          neg_x <= dx_d[32];
          neg_z <= dz_d[32];
          mag_x <= 64'(dx_d[32] ? 33'(-dx_d) : 33'(dx_d)) * 64'(ppu_x);
          mag_z <= 64'(dz_d[32] ? 33'(-dz_d) : 33'(dz_d)) * 64'(ppu_z);
          ysum  <= 34'(nh) + 34'(signed'(origin_y));
          state <= ST_S2;
        end
        ST_S2: begin
          prod  <= 66'(ysum) * 66'(signed'(scale));
          ok_x  <= okx_n;
          ok_z  <= okz_n;
          cell_x <= cx_n;
          cell_z <= cz_n;
          fx    <= fx_n;
          fz    <= fz_n;
          state <= ST_S3;
        end
        ST_S3: begin
          res.is_query <= cmd;
          res.in_map   <= ok_x && ok_z;
          res.frac_x   <= fx;
          res.frac_z   <= fz;
          res.value    <= sat;
          if (cmd == CMD_LOAD) res.addr <= pidx;
          else res.addr <= 16'(cell_z[15:0] * 16'(w_c));
          state <= ST_S4;
        end
        ST_S4: begin
          if (cmd == CMD_QUERY) res.addr <= res.addr + cell_x[15:0];
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!wk_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/hbs_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_queue
// Two-entry queue of work items between the front and the back.
// ----------------------------------------------------------------------------
module hbs_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr_valid,
  output logic          wr_stall,
  input  hbs_pkg::work_t wr_data,
  output logic          rd_valid,
  input  wire logic     rd_stall,
  output hbs_pkg::work_t rd_data
);
  import hbs_pkg::*;

  work_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end
endmodule
`default_nettype wire

/* hw/rtl/hbs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_back
// Owns the height store: writes loads, reads four neighbors of a query
// through one port and blends them along x and then z.
// ----------------------------------------------------------------------------
module hbs_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wk_valid,
  output logic             wk_stall,
  input  hbs_pkg::work_t   wk,
  input  wire logic [8:0]  map_w_c,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      ground_height,
  output logic             inside_map
);
  import hbs_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_R0   = 4'd1;
  localparam logic [3:0] ST_R1   = 4'd2;
  localparam logic [3:0] ST_R2   = 4'd3;
  localparam logic [3:0] ST_R3   = 4'd4;
  localparam logic [3:0] ST_B0   = 4'd5;
  localparam logic [3:0] ST_B1   = 4'd6;
  localparam logic [3:0] ST_B2   = 4'd7;
  localparam logic [3:0] ST_B3   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [31:0]        store [65536];
  logic [3:0]         state;
  logic [15:0]        base;
  logic [15:0]        raddr;
  logic [31:0]        rdata;
  logic               rd_en;
  logic [31:0]        ll;
  logic [31:0]        lr;
  logic [31:0]        ul;
  logic [15:0]        fx;
  logic [15:0]        fz;
  logic signed [49:0] acc;
  logic signed [33:0] a_h;
  logic signed [33:0] b_h;
  logic               loadwr;

  assign loadwr   = (state == ST_IDLE) && wk_valid && !wk.is_query;
  assign wk_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // Read address for the four neighbors in turn.
  always_comb begin
    rd_en = 1'b1;
    case (state)
      ST_R0:   raddr = base;
      ST_R1:   raddr = base + 16'd1;
      ST_R2:   raddr = base + 16'(map_w_c);
      default: raddr = base + 16'(map_w_c) + 16'd1;
    endcase
  end

  // Single-port height store.
  always_ff @(posedge clk) begin
    if (loadwr) store[wk.addr] <= wk.value;
    else if (rd_en) rdata <= store[raddr];
  end

  // One blend: p*(65536-w) + q*w, rounded half up.
  function automatic logic signed [33:0] blend(input logic signed [33:0] p,
                                               input logic signed [33:0] q,
                                               input logic [15:0] w);
    logic signed [51:0] s;
    s = 52'(p) * 52'(signed'({1'b0, 17'd65536 - 17'(w)})) +
        52'(q) * 52'(signed'({1'b0, w}));
    s = s + 52'sd32768;
    return 34'(s >>> 16);
  endfunction

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (wk_valid && wk.is_query) begin
            base <= wk.addr;
            fx   <= wk.frac_x;
            fz   <= wk.frac_z;
            if (wk.in_map) begin
              state <= ST_R0;
            end else begin
              ground_height <= 32'd0;
              inside_map    <= 1'b0;
              state         <= ST_OUT;
            end
          end
        end
        ST_R0: state <= ST_R1;
        ST_R1: begin ll <= rdata; state <= ST_R2; end
        ST_R2: begin lr <= rdata; state <= ST_R3; end
        ST_R3: begin ul <= rdata; state <= ST_B0; end
        ST_B0: begin
          a_h   <= blend(34'(signed'(ll)), 34'(signed'(lr)), fx);
          state <= ST_B1;
        end
        ST_B1: begin
          b_h   <= blend(34'(signed'(ul)), 34'(signed'(rdata)), fx);
          state <= ST_B2;
        end
        ST_B2: begin
          acc   <= 50'(blend(a_h, b_h, fz));
          state <= ST_B3;
        end
        ST_B3: begin
          ground_height <= acc[31:0];
          inside_map    <= 1'b1;
          state         <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* tb/heightmap_bilinear_sampler_core_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_core_tb
// Self-checking bench for the heightmap store and its bilinear queries.
// ----------------------------------------------------------------------------
// Each phase after the first programs every register over APB while the core
// is idle; every phase loads the part of the store that queries can touch,
// then sends a mix of loads and queries aimed at cells inside, on the edge of
// and outside the map. A scoreboard keeps its own copy of the registers and
// heights, works out the expected ground height of each accepted query, and
// checks the result beats in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

// Expected-result store with its own model of the height arithmetic.
class height_scoreboard;
  logic [31:0] org_x, org_y, org_z, ppu_x, ppu_z, scale;
  logic [8:0]  map_w, map_h;
  logic [31:0] heights [int];
  logic [32:0] height_q [$];   // {inside, ground height}
  int          mismatches;

  function new();
    org_x = 0; org_y = 0; org_z = 0;
    ppu_x = 32'd65536; ppu_z = 32'd65536;
    map_w = 9'd256; map_h = 9'd256;
    scale = 32'd65536;
    mismatches = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      hbs_pkg::REG_ORIGIN_X: org_x = v;
      hbs_pkg::REG_ORIGIN_Y: org_y = v;
      hbs_pkg::REG_ORIGIN_Z: org_z = v;
      hbs_pkg::REG_PPU_X:    ppu_x = v;
      hbs_pkg::REG_PPU_Z:    ppu_z = v;
      hbs_pkg::REG_MAP_W:    map_w = v[8:0];
      hbs_pkg::REG_MAP_H:    map_h = v[8:0];
      default:               scale = v;
    endcase
  endfunction

  // Map sizes are clamped to the store geometry.
  function int eff_size(logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  function int pending();
    return height_q.size();
  endfunction

  // World coordinate to image cell and 16-bit fraction; 0 when outside.
  function bit to_cell(logic [31:0] world, logic [31:0] org, logic [31:0] ppu, int size,
                       output int cidx, output int frac);
    longint d;
    logic [63:0] mag, half, lim, pos;
    d = longint'($signed(world)) - longint'($signed(org));
    mag = 64'(d < 0 ? -d : d) * 64'(ppu);
    half = 64'(size) << 31;
    lim = 64'(size - 1) << 32;
    cidx = 0;
    frac = 0;
    if (d < 0) begin
      if (mag > half) return 0;
      pos = half - mag;
    end else begin
      if (mag >= lim - half) return 0;
      pos = mag + half;
    end
    if (pos >= lim) return 0;
    cidx = int'(pos[63:32]);
    frac = int'(pos[31:16]);
    return 1;
  endfunction

  function longint mix(longint p, longint q, int w);
    longint s;
    s = p * (65536 - w) + q * w;
    return (s + 32768) >>> 16;
  endfunction

  function longint stored(int idx);
    return longint'($signed(heights[idx & 16'hFFFF]));
  endfunction

  // Returns 0 when the query would read an entry never written.
  function bit ground_at(logic [31:0] wx, logic [31:0] wz, output logic [32:0] res);
    int w, h, xl, zl, dx, dz, base;
    longint a, b, c;
    w = eff_size(map_w);
    h = eff_size(map_h);
    res = '0;
    if (!to_cell(wx, org_x, ppu_x, w, xl, dx) || !to_cell(wz, org_z, ppu_z, h, zl, dz))
      return 1;
    base = xl + zl * w;
    if (!heights.exists(base & 16'hFFFF) || !heights.exists((base + 1) & 16'hFFFF) ||
        !heights.exists((base + w) & 16'hFFFF) ||
        !heights.exists((base + w + 1) & 16'hFFFF))
      return 0;
    a = mix(stored(base), stored(base + 1), dx);
    b = mix(stored(base + w), stored(base + w + 1), dx);
    c = mix(a, b, dz);
    res = {1'b1, c[31:0]};
    return 1;
  endfunction

  // Color average mapped to [-1,1), offset, scaled and saturated.
  function logic [31:0] pixel_height(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint v, nh, y, p;
    v = (longint'(r) + longint'(g) + longint'(b) - 384) * 512;
    nh = (v + 196609) / 3 - 65536;
    y = nh + longint'($signed(org_y));
    p = (y * longint'($signed(scale)) + 32768) >>> 16;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function void note_beat(logic cmd, logic [15:0] idx, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b, logic [31:0] wx, logic [31:0] wz);
    logic [32:0] res;
    if (cmd == hbs_pkg::CMD_LOAD) begin
      heights[int'(idx)] = pixel_height(r, g, b);
    end else begin
      void'(ground_at(wx, wz, res));
      height_q = {height_q, res};
    end
  endfunction

  function void check_result(logic [31:0] gh, logic im);
    logic [32:0] want;
    if (height_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: height %h inside %b", gh, im);
      return;
    end
    want = height_q.pop_front();
    if (want[31:0] !== gh || want[32] !== im) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected height %h inside %b, got height %h inside %b",
                 want[31:0], want[32], gh, im);
    end
  endfunction
endclass

module heightmap_bilinear_sampler_core_tb;
  import hbs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_LOAD;
  logic [15:0] pixel_index = '0;
  logic [7:0] red = '0, green = '0, blue = '0;
  logic signed [31:0] world_x = '0, world_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] ground_height;
  logic inside_map;

  height_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  // Cell window that aimed queries pick from.
  int win_lo_x, win_hi_x, win_lo_z, win_hi_z;

  heightmap_bilinear_sampler_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("heightmap_bilinear_sampler_core test failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stall pattern.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      out_stall = quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_left = gap_len();
    end else begin
      stall_left--;
    end
  end

  // Result beats are checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(ground_height, inside_map);
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    sb.set_reg(idx, v);
  endtask

  // One input beat, after a random gap, held until accepted.
  task automatic send_beat(logic cmd, logic [15:0] idx, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [31:0] wx, logic [31:0] wz);
    int n;
    n = quiet ? 0 : gap_len();
    @(negedge clk);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1; command = cmd; pixel_index = idx;
    red = r; green = g; blue = b; world_x = wx; world_z = wz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(cmd, idx, r, g, b, wx, wz);
  endtask

  task automatic load_pixel(int idx);
    send_beat(CMD_LOAD, idx[15:0], 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
              $urandom);
  endtask

  // Wait until every result is in and the core has gone quiet.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // World coordinate that lands near a chosen cell on one axis.
  function logic [31:0] aim(logic [31:0] org, logic [31:0] ppu, int size, int lo, int hi);
    longint pos, d, w;
    int c;
    if (ppu == 0) return $urandom;
    c = $urandom_range(0, hi - lo) + lo;
    pos = (longint'(c) <<< 32) + longint'({32'b0, $urandom});
    d = (pos - (longint'(size) <<< 31)) / longint'({32'b0, ppu});
    w = longint'($signed(org)) + d;
    if (w > 64'sd2147483647 || w < -64'sd2147483648) return $urandom;
    return w[31:0];
  endfunction

  // Query beat that never reads an unwritten entry; falls back to a load.
  task automatic send_query();
    logic [31:0] wx, wz;
    logic [32:0] res;
    bit ok;
    int lx, hx, lz, hz;
    ok = 1'b0;
    for (int t = 0; t < 40 && !ok; t++) begin
      lx = win_lo_x; hx = win_hi_x; lz = win_lo_z; hz = win_hi_z;
      // Some queries step one cell past the window to hit the bounds.
      if ($urandom_range(0, 5) == 0) begin lx--; hx++; lz--; hz++; end
      wx = aim(sb.org_x, sb.ppu_x, sb.eff_size(sb.map_w), lx, hx);
      wz = aim(sb.org_z, sb.ppu_z, sb.eff_size(sb.map_h), lz, hz);
      if ($urandom_range(0, 9) == 0) wx = $urandom;
      if ($urandom_range(0, 9) == 0) wz = $urandom;
      ok = sb.ground_at(wx, wz, res);
    end
    if (ok) send_beat(CMD_QUERY, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      wx, wz);
    else load_pixel($urandom_range(0, 65535));
  endtask

  // Random mix of loads and queries.
  task automatic random_items(int n, bit pause_mid);
    int lo_cell;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) drain();
      if ($urandom_range(0, 99) < 60) begin
        send_query();
      end else if ($urandom_range(0, 1) == 0) begin
        lo_cell = $urandom_range(win_lo_x, win_hi_x + 1) +
                  $urandom_range(win_lo_z, win_hi_z + 1) * sb.eff_size(sb.map_w);
        load_pixel(lo_cell);
      end else begin
        load_pixel($urandom_range(0, 65535));
      end
    end
  endtask

  // Program all registers, then load the whole map in use.
  task automatic setup_phase(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [31:0] px, logic [31:0] pz, logic [8:0] w,
                             logic [8:0] h, logic [31:0] sc);
    drain();
    apb_write(REG_ORIGIN_X, ox);
    apb_write(REG_ORIGIN_Y, oy);
    apb_write(REG_ORIGIN_Z, oz);
    apb_write(REG_PPU_X, px);
    apb_write(REG_PPU_Z, pz);
    apb_write(REG_MAP_W, {23'b0, w});
    apb_write(REG_MAP_H, {23'b0, h});
    apb_write(REG_SCALE, sc);
    win_lo_x = 0; win_hi_x = sb.eff_size(w) - 2;
    win_lo_z = 0; win_hi_z = sb.eff_size(h) - 2;
    for (int i = 0; i < sb.eff_size(w) * sb.eff_size(h); i++) load_pixel(i);
  endtask

  function logic [31:0] rand_ppu();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(32'h1000, 32'h100000);
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Register defaults: full-size map, only a patch around the center loaded.
    win_lo_x = 126; win_hi_x = 129; win_lo_z = 126; win_hi_z = 129;
    for (int z = 126; z <= 130; z++)
      for (int x = 126; x <= 130; x++) load_pixel(x + z * 256);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'h0, 32'h0);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'h7FFFFFFF, 32'h0);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'h0, 32'h80000000);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'h80000000, 32'h7FFFFFFF);
    random_items(55, 1'b0);

    // Smallest map, with directed color and index extremes.
    setup_phase(32'h0, 32'h0, 32'h0, 32'd65536, 32'd65536, 9'd2, 9'd2, 32'd65536);
    send_beat(CMD_LOAD, 16'h0, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0);
    send_beat(CMD_LOAD, 16'h1, 8'hFF, 8'hFF, 8'hFF, 32'h0, 32'h0);
    send_beat(CMD_LOAD, 16'h2, 8'hFF, 8'h00, 8'h80, 32'h0, 32'h0);
    send_beat(CMD_LOAD, 16'hFFFF, 8'h7F, 8'h80, 8'h01, 32'h0, 32'h0);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'h0, 32'h0);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'hFFFF8000, 32'hFFFF0000);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'h00010000, 32'h0);
    send_beat(CMD_QUERY, 16'h0, 8'h0, 8'h0, 8'h0, 32'hFFFEFFFF, 32'h0);
    random_items(55, 1'b0);

    // Random settings; the sender once waits for every result mid-phase.
    setup_phase($urandom, $urandom_range(0, 32'h20000), $urandom, rand_ppu(), rand_ppu(),
                9'($urandom_range(2, 12)), 9'($urandom_range(2, 12)), $urandom);
    random_items(55, 1'b1);

    // Register extremes, map sizes below the minimum.
    setup_phase(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h0,
                9'd0, 9'd1, 32'h7FFFFFFF);
    random_items(55, 1'b0);

    // Widest map after clamping, most negative offset and scale.
    setup_phase($urandom, 32'h80000000, $urandom, rand_ppu(), rand_ppu(),
                9'd511, 9'd2, 32'h80000000);
    random_items(55, 1'b0);

    for (int p = 0; p < 2; p++) begin
      quiet = (p == 1);
      setup_phase($urandom, ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 32'h20000),
                  $urandom, rand_ppu(), rand_ppu(), 9'($urandom_range(2, 12)),
                  9'($urandom_range(2, 12)), $urandom);
      random_items(55, 1'b0);
    end
    quiet = 1'b0;

    drain();
    if (sb.mismatches == 0)
      $display("heightmap_bilinear_sampler_core test passed");
    else
      $display("heightmap_bilinear_sampler_core test failed");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/hbs_pkg.sv
hw/rtl/hbs_front.sv
hw/rtl/hbs_queue.sv
hw/rtl/hbs_back.sv
hw/rtl/heightmap_bilinear_sampler_core.sv
tb/heightmap_bilinear_sampler_core_tb.sv
